[sv/lcsd_pkg.sv]
// Shared types and constants for the load-cell settling detector.
// Used by lcsd_div and load_cell_settle_detector_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcsd_pkg;

  // Field widths
  localparam int RAW_W    = 24;
  localparam int TIME_W   = 32;
  localparam int WEIGHT_W = 32;
  localparam int CFG_D_W  = 32;
  localparam int CFG_A_W  = 3;
  localparam int SUM_W    = 40;   // enough for up to 256 weights
  localparam int RUN_W    = 8;

  // Shared divider: 41-bit dividend (|net| << 16), 24-bit divisor
  localparam int DIV_N_W = 41;
  localparam int DIV_D_W = 24;

  localparam int WINDOW_LENGTH_DEF = 10;

  // Converter saturation codes
  localparam logic [RAW_W-1:0] RAW_SAT_HIGH = 24'h7F_FFFF;
  localparam logic [RAW_W-1:0] RAW_SAT_LOW  = 24'h80_0000;

  // Register reset values
  localparam logic [23:0] TARE_RST     = 24'd0;
  localparam logic [23:0] CPG_RST      = 24'd115712;
  localparam logic [23:0] THR_RST      = 24'd2560;
  localparam logic [7:0]  NEEDED_RST   = 8'd3;
  localparam logic [31:0] INTERVAL_RST = 32'd5000;

  typedef enum logic [CFG_A_W-1:0] {
    REG_TARE_OFFSET      = 3'd0,
    REG_COUNTS_PER_GRAM  = 3'd1,
    REG_SETTLE_THRESHOLD = 3'd2,
    REG_SETTLE_COUNT     = 3'd3,
    REG_LIVE_INTERVAL    = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_STABLE_ON  = 2'd0,
    KIND_STABLE_OFF = 2'd1,
    KIND_LIVE       = 2'd2
  } report_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NET,
    ST_WDIV,
    ST_SUM,
    ST_ASTART,
    ST_ADIV,
    ST_STEP
  } state_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_sample;
    logic [TIME_W-1:0]       time_ms;
    logic                    event_tag_present;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                 report_kind;
    logic signed [WEIGHT_W-1:0] weight_q8;
    logic                       last_of_run;
  } out_item_t;

endpackage

`default_nettype wire

[sv/load_cell_settle_detector_top.sv]
// Load-cell settling detector: scaling, moving average, stability and live reports.
// Depends on lcsd_pkg and lcsd_div.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        sink       in_valid / in_ready     in_data  (lcsd_pkg::in_item_t)
// out       source     out_valid / out_ready   out_data (lcsd_pkg::out_item_t)
// cfg       sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A request runs from acceptance through a net step, two passes through the
// shared one-bit-per-cycle divider (41 quotient bits each; weight scale, then
// window average), window update, average start and commit, then returns to
// idle, where the next request can be accepted. A zero scale skips the first
// pass. A saturated sample is taken with no effect. Reset (sync, active high)
// restores register defaults and clears the sequencer, divider, window, settle
// and output-count state. Up to two results per request sit in a two-entry
// output buffer; the next request is taken while they wait, and only the final
// commit step stalls until the buffer has drained. cfg_ready is always high.

module load_cell_settle_detector_top #(
  parameter int WINDOW_LENGTH = lcsd_pkg::WINDOW_LENGTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  lcsd_pkg::in_item_t          in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output lcsd_pkg::out_item_t               out_data,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [lcsd_pkg::CFG_A_W-1:0]      cfg_index,
  input  wire  [lcsd_pkg::CFG_D_W-1:0]      cfg_data
);

  localparam int SLOT_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W  = lcsd_pkg::SUM_W;
  localparam int N_W    = lcsd_pkg::DIV_N_W;
  localparam int D_W    = lcsd_pkg::DIV_D_W;

  // ---------------- configuration registers ----------------
  logic signed [23:0] tare_offset;
  logic [23:0]        counts_per_gram;
  logic [23:0]        settle_threshold;
  logic [7:0]         settle_count_needed;
  logic [31:0]        live_interval_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tare_offset         <= lcsd_pkg::TARE_RST;
      counts_per_gram     <= lcsd_pkg::CPG_RST;
      settle_threshold    <= lcsd_pkg::THR_RST;
      settle_count_needed <= lcsd_pkg::NEEDED_RST;
      live_interval_ms    <= lcsd_pkg::INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lcsd_pkg::REG_TARE_OFFSET:      tare_offset         <= cfg_data[23:0];
        lcsd_pkg::REG_COUNTS_PER_GRAM:  counts_per_gram     <= cfg_data[23:0];
        lcsd_pkg::REG_SETTLE_THRESHOLD: settle_threshold    <= cfg_data[23:0];
        lcsd_pkg::REG_SETTLE_COUNT:     settle_count_needed <= cfg_data[7:0];
        lcsd_pkg::REG_LIVE_INTERVAL:    live_interval_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  lcsd_pkg::state_t state, state_next;

  logic in_fire;
  logic in_sat;
  logic div_start;
  logic div_done;
  logic win_we;
  logic step_fire;
  logic [1:0] ocnt;

  assign in_fire = in_valid && in_ready;
  assign in_sat  = (in_data.raw_sample == lcsd_pkg::RAW_SAT_HIGH) ||
                   (in_data.raw_sample == lcsd_pkg::RAW_SAT_LOW);

  always_comb begin
    state_next = state;
    unique case (state)
      lcsd_pkg::ST_IDLE:   if (in_fire && !in_sat) state_next = lcsd_pkg::ST_NET;
      lcsd_pkg::ST_NET:    state_next = (counts_per_gram == '0) ? lcsd_pkg::ST_SUM
                                                                : lcsd_pkg::ST_WDIV;
      lcsd_pkg::ST_WDIV:   if (div_done) state_next = lcsd_pkg::ST_SUM;
      lcsd_pkg::ST_SUM:    state_next = lcsd_pkg::ST_ASTART;
      lcsd_pkg::ST_ASTART: state_next = lcsd_pkg::ST_ADIV;
      lcsd_pkg::ST_ADIV:   if (div_done) state_next = lcsd_pkg::ST_STEP;
      lcsd_pkg::ST_STEP:   if (ocnt == 2'd0) state_next = lcsd_pkg::ST_IDLE;
      default:             state_next = lcsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == lcsd_pkg::ST_IDLE);
    div_start = ((state == lcsd_pkg::ST_NET) && (counts_per_gram != '0)) ||
                (state == lcsd_pkg::ST_ASTART);
    win_we    = (state == lcsd_pkg::ST_SUM);
    step_fire = (state == lcsd_pkg::ST_STEP) && (ocnt == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lcsd_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // ---------------- sample, net, weight ----------------
  lcsd_pkg::in_item_t smp;
  logic               net_neg;
  logic               sum_neg;
  logic signed [31:0] weight;
  logic signed [31:0] avg;

  logic [24:0]        net;
  logic [24:0]        net_mag;
  logic [N_W-1:0]     sum_mag;
  logic [N_W-1:0]     div_dividend;
  logic [D_W-1:0]     div_divisor;
  logic [N_W-1:0]     div_q;
  logic [31:0]        w_sat;
  logic [31:0]        avg_q;

  always_comb begin
    net     = {smp.raw_sample[23], smp.raw_sample} - {tare_offset[23], tare_offset};
    net_mag = net[24] ? (25'd0 - net) : net;
    // sign taken straight from the sum, which is already updated at average start
    sum_mag = {1'b0, (window_sum[SUM_W-1] ? (SUM_W'(0) - window_sum) : window_sum)};
    if (state == lcsd_pkg::ST_NET) begin
      div_dividend = {net_mag, 16'd0};
      div_divisor  = counts_per_gram;
    end else begin
      div_dividend = sum_mag;
      div_divisor  = D_W'(window_fill);
    end
    // sign and 32-bit saturation of the scaled weight
    if (!net_neg)
      w_sat = (div_q > N_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q[31:0];
    else
      w_sat = (div_q > N_W'(32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - div_q[31:0]);
    // a window mean never leaves the 32-bit range
    avg_q = sum_neg ? (32'd0 - div_q[31:0]) : div_q[31:0];
  end

  lcsd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------- window ----------------
  logic [31:0]       win_mem [WINDOW_LENGTH];
  logic [31:0]       win_rd;
  logic [SLOT_W-1:0] write_slot;
  logic [FILL_W-1:0] window_fill;
  logic [SUM_W-1:0]  window_sum;
  logic              win_full;
  logic [SUM_W-1:0]  sum_next;

  assign win_full = (window_fill == FILL_W'(WINDOW_LENGTH));

  always_comb begin
    sum_next = window_sum + {{(SUM_W-32){weight[31]}}, weight}
             - (win_full ? {{(SUM_W-32){win_rd[31]}}, win_rd} : SUM_W'(0));
  end

  // the oldest entry is read ahead; slot is steady since the request started
  always_ff @(posedge clk) begin
    if (win_we) win_mem[write_slot] <= weight;
    win_rd <= win_mem[write_slot];
  end

  always_ff @(posedge clk) begin
    if (in_fire) smp <= in_data;
    if (state == lcsd_pkg::ST_NET) begin
      net_neg <= net[24];
      if (counts_per_gram == '0) weight <= '0;
    end
    if ((state == lcsd_pkg::ST_WDIV) && div_done) weight <= w_sat;
    if (state == lcsd_pkg::ST_ASTART) sum_neg <= window_sum[SUM_W-1];
    if ((state == lcsd_pkg::ST_ADIV) && div_done) avg <= avg_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot  <= '0;
      window_fill <= '0;
      window_sum  <= '0;
    end else if (win_we) begin
      window_sum  <= sum_next;
      if (!win_full) window_fill <= window_fill + 1'b1;
      write_slot  <= (write_slot == SLOT_W'(WINDOW_LENGTH - 1)) ? '0
                                                                : write_slot + 1'b1;
    end
  end

  // ---------------- settle rules ----------------
  logic signed [31:0] previous_average;
  logic [7:0]         settle_run;
  logic               stable_flag;
  logic signed [31:0] held_weight;
  logic [31:0]        last_live_time;

  logic [32:0] d_prev, d_prev_abs, d_stab, d_stab_abs;
  logic [7:0]  run_new;
  logic        go_on, go_off, avg_pos, emit_ev, live;
  logic [31:0] elapsed;
  lcsd_pkg::out_item_t r0, r1;
  logic [1:0]  rcnt;

  always_comb begin
    d_prev     = {avg[31], avg} - {previous_average[31], previous_average};
    d_prev_abs = d_prev[32] ? (33'd0 - d_prev) : d_prev;
    d_stab     = {avg[31], avg} - {held_weight[31], held_weight};
    d_stab_abs = d_stab[32] ? (33'd0 - d_stab) : d_stab;

    if (d_prev_abs < {9'd0, settle_threshold})
      run_new = (settle_run == 8'hFF) ? settle_run : settle_run + 1'b1;
    else
      run_new = '0;

    // on and off are exclusive: on needs the old flag low, off needs it high
    go_on   = !stable_flag && (run_new >= settle_count_needed);
    go_off  = stable_flag && (d_stab_abs > {9'd0, settle_threshold});
    avg_pos = !avg[31] && (avg != '0);
    emit_ev = (go_on || go_off) && avg_pos && smp.event_tag_present;
    elapsed = smp.time_ms - last_live_time;
    live    = (elapsed >= live_interval_ms);

    r0.report_kind = go_on ? lcsd_pkg::KIND_STABLE_ON : lcsd_pkg::KIND_STABLE_OFF;
    r0.weight_q8   = avg;
    r0.last_of_run = !live;
    r1.report_kind = lcsd_pkg::KIND_LIVE;
    r1.weight_q8   = avg;
    r1.last_of_run = 1'b1;
    rcnt           = 2'(emit_ev) + 2'(live);
    if (!emit_ev) r0 = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_average <= '0;
      settle_run       <= '0;
      stable_flag      <= 1'b0;
      held_weight      <= '0;
      last_live_time   <= '0;
    end else if (step_fire) begin
      previous_average <= avg;
      settle_run       <= run_new;
      if (go_on) begin
        stable_flag <= 1'b1;
        held_weight <= avg;
      end else if (go_off) begin
        stable_flag <= 1'b0;
      end
      if (live) last_live_time <= smp.time_ms;
    end
  end

  // ---------------- output buffer ----------------
  lcsd_pkg::out_item_t ob0, ob1;

  assign out_valid = (ocnt != 2'd0);
  assign out_data  = ob0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else if (step_fire) begin
      ocnt <= rcnt;
    end else if (out_valid && out_ready) begin
      ocnt <= ocnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      ob0 <= r0;
      ob1 <= r1;
    end else if (out_valid && out_ready) begin
      ob0 <= ob1;
    end
  end

endmodule

`default_nettype wire

[sv/lcsd_div.sv]
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on lcsd_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module lcsd_div (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  input  wire  [lcsd_pkg::DIV_N_W-1:0]     dividend,
  input  wire  [lcsd_pkg::DIV_D_W-1:0]     divisor,
  output logic                             done,
  output logic [lcsd_pkg::DIV_N_W-1:0]     quotient
);

  localparam int N_W   = lcsd_pkg::DIV_N_W;
  localparam int D_W   = lcsd_pkg::DIV_D_W;
  localparam int CNT_W = $clog2(N_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dvs;
  logic [N_W-1:0]   qreg;

  logic [D_W:0]     rem_sh;
  logic [D_W:0]     rem_sub;
  logic             q_bit;

  // shift in the next dividend bit, trial subtract
  always_comb begin
    rem_sh  = {rem, qreg[N_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    q_bit   = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvs  <= divisor;
      qreg <= dividend;
    end else if (busy) begin
      rem  <= q_bit ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
      qreg <= {qreg[N_W-2:0], q_bit};
    end
  end

  assign quotient = qreg;

endmodule

`default_nettype wire

[tb/tb_load_cell_settle_detector_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for load_cell_settle_detector_top: directed and random samples,
// a behavioral predictor of the settling logic, in-order checks of every report.
// Depends on lcsd_pkg and the detector RTL; needs no files or arguments.

module tb_load_cell_settle_detector_top;

  localparam int     WIN_LEN      = lcsd_pkg::WINDOW_LENGTH_DEF;
  localparam int     DRAIN_CYCLES = 200;      // settling margin after the last report
  localparam int     SHOWN_LIMIT  = 100;      // keep the log short on a bad build
  localparam longint RAW_MAX_OK   = 8388606;  // largest non-saturated reading
  localparam longint RAW_MIN_OK   = -8388607;

  // --------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  lcsd_pkg::in_item_t            in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  lcsd_pkg::out_item_t           out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [lcsd_pkg::CFG_A_W-1:0]  cfg_index = '0;
  logic [lcsd_pkg::CFG_D_W-1:0]  cfg_data  = '0;

  load_cell_settle_detector_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: register copies plus the detector's own state
  // --------------------------------------------------------------------------
  longint      tare_cnt    = 0;
  longint      scale_cpg   = longint'(lcsd_pkg::CPG_RST);
  longint      thr_q8      = longint'(lcsd_pkg::THR_RST);
  int unsigned need_run    = 32'(lcsd_pkg::NEEDED_RST);
  logic [31:0] live_period = lcsd_pkg::INTERVAL_RST;

  int          win_w [WIN_LEN];
  longint      win_sum     = 0;
  int unsigned win_fill    = 0;
  int unsigned win_slot    = 0;
  longint      prev_avg    = 0;
  int unsigned run_len     = 0;
  bit          settled     = 1'b0;
  longint      stable_w    = 0;
  logic [31:0] live_stamp  = '0;

  // Request traffic and bookkeeping
  lcsd_pkg::in_item_t  sample_q [$];          // requests waiting for the driver
  lcsd_pkg::out_item_t pending_reports [$];   // predicted reports, oldest first
  logic [31:0] clock_ms        = '0;  // running sample time for well-formed runs
  int          mismatches      = 0;
  int          samples_sent    = 0;
  int          saturated_sent  = 0;
  int          settings_loaded = 0;
  int          kind_seen [3]   = '{0, 0, 0};

  // Handshake bookkeeping between the edge-sampled monitor and the drivers
  logic        in_taken  = 1'b0;
  logic        out_taken = 1'b0;
  int          send_gap  = 0;
  int          hold_gap  = 0;
  bit          in_burst  = 1'b0;
  bit          out_burst = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Works out the reports one accepted sample causes and queues them.
  function automatic void compute_reports(input lcsd_pkg::in_item_t s);
    longint              raw;
    longint              wt;
    longint              avg;
    logic [31:0]         elapsed;
    lcsd_pkg::out_item_t r;
    lcsd_pkg::out_item_t batch [$];

    if (s.raw_sample == lcsd_pkg::RAW_SAT_HIGH || s.raw_sample == lcsd_pkg::RAW_SAT_LOW) begin
      saturated_sent++;
      return;
    end
    raw = {{40{s.raw_sample[lcsd_pkg::RAW_W-1]}}, s.raw_sample};

    // Tare, then scale; a zero scale pins the weight to zero
    if (scale_cpg == 0) wt = 0;
    else wt = clamp32(((raw - tare_cnt) * 65536) / scale_cpg);

    // Moving window: the oldest entry drops out only once the window is full
    if (win_slot >= WIN_LEN) win_slot = 0;
    if (win_fill >= WIN_LEN) win_sum -= win_w[win_slot];
    else win_fill++;
    win_w[win_slot] = int'(wt);
    win_sum += wt;
    win_slot = (win_slot + 1 >= WIN_LEN) ? 0 : win_slot + 1;
    avg = clamp32(win_sum / longint'(win_fill));

    // Run of small steps, saturating at 255
    if (mag(avg - prev_avg) < thr_q8) begin
      if (run_len < 255) run_len++;
    end else begin
      run_len = 0;
    end
    prev_avg = avg;

    r.weight_q8   = avg[31:0];
    r.last_of_run = 1'b0;
    if (!settled && run_len >= need_run) begin
      settled  = 1'b1;
      stable_w = avg;
      if (avg > 0 && s.event_tag_present) begin
        r.report_kind = lcsd_pkg::KIND_STABLE_ON;
        batch.push_back(r);
      end
    end
    if (settled && mag(avg - stable_w) > thr_q8) begin
      settled = 1'b0;
      if (avg > 0 && s.event_tag_present) begin
        r.report_kind = lcsd_pkg::KIND_STABLE_OFF;
        batch.push_back(r);
      end
    end
    elapsed = s.time_ms - live_stamp;
    if (elapsed >= live_period) begin
      r.report_kind = lcsd_pkg::KIND_LIVE;
      batch.push_back(r);
      live_stamp = s.time_ms;
    end

    if (batch.size() != 0) batch[batch.size()-1].last_of_run = 1'b1;
    foreach (batch[i]) pending_reports.push_back(batch[i]);
  endfunction

  function automatic void flag_mismatch(input string what, input longint exp_v,
                                        input longint got_v);
    mismatches++;
    if (mismatches <= SHOWN_LIMIT)
      $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, got_v);
    else if (mismatches == SHOWN_LIMIT + 1)
      $display("%0t: further differences are counted but not shown", $time);
  endfunction

  function automatic void check_report(input lcsd_pkg::out_item_t got);
    lcsd_pkg::out_item_t want;
    if (pending_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOWN_LIMIT)
        $display("%0t: report with none expected, got kind %0d weight %0d last %0b",
                 $time, got.report_kind, got.weight_q8, got.last_of_run);
      return;
    end
    want = pending_reports.pop_front();
    if (want.report_kind < 3) kind_seen[want.report_kind]++;
    if (got.report_kind !== want.report_kind)
      flag_mismatch("report_kind", want.report_kind, got.report_kind);
    if (got.weight_q8 !== want.weight_q8)
      flag_mismatch("weight_q8", want.weight_q8, got.weight_q8);
    if (got.last_of_run !== want.last_of_run)
      flag_mismatch("last_of_run", want.last_of_run, got.last_of_run);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken  <= !rst && in_valid && in_ready;
    out_taken <= !rst && out_valid && out_ready;
    if (!rst) begin
      if (in_valid && in_ready) compute_reports(in_data);
      if (out_valid && out_ready) check_report(out_data);
    end
  end

  // --------------------------------------------------------------------------
  // Request driver: fed from sample_q, changes at the falling edge. After each
  // request a random gap is drawn before the next, except in burst stretches.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_data  <= sample_q.pop_front();
          in_valid <= 1'b1;
          send_gap = in_burst ? 0 : $urandom_range(0, 5);
          if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: after each report, out_ready drops for a random stall, except in burst stretches
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        hold_gap = out_burst ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_sample(input logic [lcsd_pkg::RAW_W-1:0] raw, input logic [31:0] t,
                            input bit tag);
    lcsd_pkg::in_item_t it;
    it.raw_sample        = raw;
    it.time_ms           = t;
    it.event_tag_present = tag;
    sample_q.push_back(it);
    samples_sent++;
  endtask

  // Holds the sender until every predicted report is back, then lets any
  // request with no report finish before registers are touched.
  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid || pending_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input lcsd_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lcsd_pkg::REG_TARE_OFFSET:      tare_cnt    = {{40{val[23]}}, val[23:0]};
      lcsd_pkg::REG_COUNTS_PER_GRAM:  scale_cpg   = longint'(val[23:0]);
      lcsd_pkg::REG_SETTLE_THRESHOLD: thr_q8      = longint'(val[23:0]);
      lcsd_pkg::REG_SETTLE_COUNT:     need_run    = 32'(val[7:0]);
      lcsd_pkg::REG_LIVE_INTERVAL:    live_period = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [31:0] tare, input logic [31:0] cpg,
                               input logic [31:0] thr, input logic [31:0] need,
                               input logic [31:0] period);
    write_reg(lcsd_pkg::REG_TARE_OFFSET, tare);
    write_reg(lcsd_pkg::REG_COUNTS_PER_GRAM, cpg);
    write_reg(lcsd_pkg::REG_SETTLE_THRESHOLD, thr);
    write_reg(lcsd_pkg::REG_SETTLE_COUNT, need);
    write_reg(lcsd_pkg::REG_LIVE_INTERVAL, period);
    @(negedge clk) cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  function automatic logic [31:0] rand_signed(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic load_random_settings();
    load_settings(rand_signed(2000000), $urandom_range(256, 500000),
                  $urandom_range(64, 20000), $urandom_range(1, 10),
                  $urandom_range(1, 6000));
  endtask

  // A plateau: a run of readings around one load with noise sized to the
  // threshold, so the average settles, drifts and jumps like a real scale.
  task automatic queue_plateau(input int len);
    longint lvl;
    longint amp;
    longint raw;
    longint grams;
    bit     tag;
    if ($urandom_range(0, 9) == 0) grams = -longint'($urandom_range(0, 2000));
    else grams = $urandom_range(0, 5000);
    lvl = tare_cnt + grams * scale_cpg / 256;
    amp = thr_q8 * scale_cpg / 262144;
    if (amp > 100000) amp = 100000;
    tag = ($urandom_range(0, 9) != 0);
    repeat (len) begin
      raw = lvl + longint'($urandom_range(0, 2 * amp)) - amp;
      if (raw > RAW_MAX_OK) raw = RAW_MAX_OK;
      if (raw < RAW_MIN_OK) raw = RAW_MIN_OK;
      clock_ms += $urandom_range(0, 1200);
      add_sample(raw[lcsd_pkg::RAW_W-1:0], clock_ms, tag);
    end
  endtask

  // Mostly plateaus; the rest is noise: any code, saturated codes, odd times.
  task automatic queue_random_phase(input int count);
    int          done;
    int          len;
    logic [23:0] raw;
    logic [31:0] t;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 99) < 15) begin
        case ($urandom_range(0, 19))
          0:       raw = lcsd_pkg::RAW_SAT_HIGH;
          1:       raw = lcsd_pkg::RAW_SAT_LOW;
          default: raw = 24'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0) begin
          t = $urandom;
        end else begin
          clock_ms += $urandom_range(0, 1200);
          t = clock_ms;
        end
        add_sample(raw, t, 1'($urandom_range(0, 1)));
        done++;
      end else begin
        len = $urandom_range(3, 25);
        if (len > count - done) len = count - done;
        queue_plateau(len);
        done += len;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Register defaults: saturation codes, extreme readings, stable on, live,
    // stable off, tag cleared, negative load, time at its top value.
    add_sample(lcsd_pkg::RAW_SAT_HIGH, 32'd0, 1'b1);
    add_sample(lcsd_pkg::RAW_SAT_LOW, 32'hFFFF_FFFF, 1'b1);
    add_sample(24'h7F_FFFE, 32'd100, 1'b1);
    add_sample(24'h7F_FFFE, 32'd200, 1'b1);
    add_sample(24'h7F_FFFE, 32'd300, 1'b1);
    add_sample(24'h7F_FFFE, 32'd400, 1'b1);   // run reaches 3 -> stable on
    add_sample(24'h7F_FFFE, 32'd5400, 1'b0);  // live only
    add_sample(24'h80_0001, 32'd5500, 1'b1);  // big drop -> stable off
    add_sample(24'h80_0001, 32'd5600, 1'b0);
    add_sample(24'h80_0001, 32'd5700, 1'b0);
    add_sample(24'h80_0001, 32'hFFFF_FFFF, 1'b1);
    add_sample(24'h00_0000, 32'd0, 1'b1);
    wait_drained();

    // Zero scale and the shortest live interval; a repeated time gives no live
    load_settings(32'd0, 32'd0, 32'(lcsd_pkg::THR_RST), 32'(lcsd_pkg::NEEDED_RST), 32'd1);
    add_sample(24'd123456, 32'd10, 1'b1);
    add_sample(24'd555555, 32'd10, 1'b1);
    add_sample(24'h00_0000, 32'd11, 1'b1);
    add_sample(24'hFF_FFFF, 32'd12, 1'b0);
    wait_drained();

    // Most negative tare with unit scale: weight clips high. Widest threshold,
    // longest run, longest interval (reached only one ms behind the last live).
    load_settings(32'hFF80_0000, 32'd1, 32'h00FF_FFFF, 32'd255, 32'hFFFF_FFFF);
    add_sample(24'h7F_FFFE, live_stamp - 32'd1, 1'b1);
    add_sample(24'h7F_FFFE, live_stamp + 32'd5, 1'b1);
    add_sample(24'h80_0001, live_stamp + 32'd9, 1'b1);
    wait_drained();

    // Most positive tare: weight clips low. Zero threshold, run of one.
    load_settings(32'h007F_FFFF, 32'd1, 32'd0, 32'd1, 32'd3);
    add_sample(24'h80_0001, live_stamp + 32'd1, 1'b1);
    add_sample(24'h80_0001, live_stamp + 32'd2, 1'b1);
    add_sample(24'h00_0000, live_stamp + 32'd7, 1'b1);
    wait_drained();

    // Random part: each phase starts from an idle block with fresh registers
    clock_ms = live_stamp;
    load_settings(rand_signed(50000), 32'(lcsd_pkg::CPG_RST), 32'(lcsd_pkg::THR_RST),
                  32'(lcsd_pkg::NEEDED_RST), lcsd_pkg::INTERVAL_RST);
    queue_random_phase(120);
    wait_drained();

    clock_ms = 32'hFFFF_F000 + $urandom_range(0, 4095);  // time wraps here
    load_random_settings();
    queue_random_phase(120);
    wait_drained();

    // Everything counts as a small step: run saturates, stable on at 255
    load_settings(rand_signed(1000000), $urandom_range(10000, 200000), 32'h00FF_FFFF,
                  32'd255, $urandom_range(2000, 20000));
    queue_random_phase(270);
    wait_drained();

    // Largest scale, tight threshold, live report on almost every sample
    load_settings(rand_signed(100), 32'h00FF_FFFF, $urandom_range(1, 64), 32'd1, 32'd1);
    queue_random_phase(120);
    wait_drained();

    load_random_settings();
    queue_random_phase(110);
    wait_drained();

    load_random_settings();
    queue_random_phase(110);
    wait_drained();

    $display("Sent %0d samples (%0d saturated) over %0d register loads plus defaults.",
             samples_sent, saturated_sent, settings_loaded);
    $display("Checked reports: %0d stable-on, %0d stable-off, %0d live.",
             kind_seen[0], kind_seen[1], kind_seen[2]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs roughly 1.2 ms of simulated time
  initial begin
    #(64'd10_000_000);
    $display("%0t: run did not complete, %0d reports still expected",
             $time, pending_reports.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
